>>> rtl/wmb_pkg.sv
`timescale 1ns / 1ps
package wmb_pkg;

  // Window capacity and derived widths
  localparam int WINDOW  = 64;
  localparam int ADDR_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CNT_W   = $clog2(WINDOW + 1);

  localparam int DATA_W  = 32;
  localparam int FACT_W  = 17;
  localparam int MUL_A_W = FACT_W + 2;
  localparam int MUL_B_W = DATA_W + 1;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int SHIFT_Q = FACT_W;

  localparam logic [FACT_W-1:0] FACTOR_ONE   = 17'd65536;
  localparam logic [FACT_W-1:0] FACTOR_RESET = 17'd42598;

  // APB register map
  localparam int PADDR_W = 3;
  localparam logic REG_MODE   = 1'b0;
  localparam logic REG_FACTOR = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SHIFT,
    ST_RD_LO,
    ST_RD_HI,
    ST_RD_MID,
    ST_MUL_MID,
    ST_MUL_SIDE,
    ST_SUM
  } state_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [DATA_W-1:0] wdata;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    logic signed [MUL_A_W-1:0] a;
    logic signed [MUL_B_W-1:0] b;
  } mul_op_t;

endpackage

>>> rtl/wmb_store.sv
`timescale 1ns / 1ps
module wmb_store (
  input  logic                            clk,
  input  wmb_pkg::mem_req_t               req,
  output logic [wmb_pkg::DATA_W-1:0]      rdata
);

  logic [wmb_pkg::DATA_W-1:0] mem [wmb_pkg::WINDOW];

  // Single write port, registered read port
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata <= mem[req.raddr];
  end

endmodule

>>> rtl/wmb_mul.sv
`timescale 1ns / 1ps
module wmb_mul (
  input  logic                              clk,
  input  wmb_pkg::mul_op_t                  op,
  output logic signed [wmb_pkg::PROD_W-1:0] prod
);

  // Shared signed multiplier, product registered
  always_ff @(posedge clk) begin
    prod <= wmb_pkg::PROD_W'(op.a) * wmb_pkg::PROD_W'(op.b);
  end

endmodule

>>> rtl/wmb_ctrl.sv
`timescale 1ns / 1ps
module wmb_ctrl (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic signed [wmb_pkg::DATA_W-1:0]  sample,
  input  logic                               last,
  input  logic                               blend_mode,
  input  logic [wmb_pkg::FACT_W-1:0]         blend_factor,
  output wmb_pkg::mem_req_t                  req,
  input  logic [wmb_pkg::DATA_W-1:0]         rdata,
  output wmb_pkg::mul_op_t                   mul_op,
  input  logic signed [wmb_pkg::PROD_W-1:0]  prod,
  output logic                               busy,
  output logic                               done,
  output logic signed [wmb_pkg::DATA_W-1:0]  median,
  output logic [6:0]                         sample_count,
  output logic                               truncated
);

  wmb_pkg::state_t state, state_next;

  logic [wmb_pkg::CNT_W-1:0]          fill, fill_next;
  logic                               dropped, dropped_next;
  logic [wmb_pkg::ADDR_W-1:0]         j, j_next;
  logic signed [wmb_pkg::DATA_W-1:0]  v, v_next;
  logic                               last_q, last_q_next;
  logic signed [wmb_pkg::DATA_W:0]    side, side_next;
  logic signed [wmb_pkg::PROD_W-1:0]  acc, acc_next;
  logic                               done_next;
  logic signed [wmb_pkg::DATA_W-1:0]  median_next;
  logic [6:0]                         count_next;
  logic                               trunc_next;

  logic                               use_blend;
  logic [wmb_pkg::ADDR_W-1:0]         mid, lo_addr, hi_addr;
  logic [wmb_pkg::FACT_W-1:0]         f_eff, f_rem;
  logic signed [wmb_pkg::DATA_W:0]    pair_sum;
  logic signed [wmb_pkg::PROD_W-1:0]  total;

  // Median addressing from the current count
  assign use_blend = blend_mode && (fill >= wmb_pkg::CNT_W'(3));
  assign mid       = wmb_pkg::ADDR_W'(fill >> 1);
  assign lo_addr   = (use_blend || !fill[0]) ? mid - 1'b1 : mid;
  assign hi_addr   = use_blend ? mid + 1'b1 : mid;

  // Blend weights, factor clamped to one
  assign f_eff = (blend_factor > wmb_pkg::FACTOR_ONE) ? wmb_pkg::FACTOR_ONE : blend_factor;
  assign f_rem = wmb_pkg::FACTOR_ONE - f_eff;

  assign pair_sum = side + {rdata[wmb_pkg::DATA_W-1], rdata};
  assign total    = acc + prod;

  assign busy = (state != wmb_pkg::ST_IDLE);

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= wmb_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Control and datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      fill    <= '0;
      dropped <= 1'b0;
      done    <= 1'b0;
    end else begin
      fill    <= fill_next;
      dropped <= dropped_next;
      done    <= done_next;
    end
    j            <= j_next;
    v            <= v_next;
    last_q       <= last_q_next;
    side         <= side_next;
    acc          <= acc_next;
    median       <= median_next;
    sample_count <= count_next;
    truncated    <= trunc_next;
  end

  // Sequencer: insertion walk, then median fetch and, in blend mode, the blend
  always_comb begin
    state_next   = state;
    fill_next    = fill;
    dropped_next = dropped;
    j_next       = j;
    v_next       = v;
    last_q_next  = last_q;
    side_next    = side;
    acc_next     = acc;
    done_next    = 1'b0;
    median_next  = median;
    count_next   = sample_count;
    trunc_next   = truncated;
    req.we       = 1'b0;
    req.waddr    = j;
    req.wdata    = v;
    req.raddr    = wmb_pkg::ADDR_W'(fill - 1'b1);
    mul_op.a     = '0;
    mul_op.b     = '0;

    case (state)
      wmb_pkg::ST_IDLE: begin
        // top entry is being read for the first compare
        if (start) begin
          v_next      = sample;
          last_q_next = last;
          if (fill < wmb_pkg::CNT_W'(wmb_pkg::WINDOW)) begin
            j_next     = wmb_pkg::ADDR_W'(fill);
            state_next = wmb_pkg::ST_SHIFT;
          end else begin
            dropped_next = 1'b1;
            if (last) begin
              state_next = wmb_pkg::ST_RD_LO;
            end
          end
        end
      end

      wmb_pkg::ST_SHIFT: begin
        req.we = 1'b1;
        if (j != '0 && $signed(rdata) > v) begin
          // move larger entry up one slot, fetch the next one down
          req.wdata = rdata;
          req.raddr = j - 2'd2;
          j_next    = j - 1'b1;
        end else begin
          fill_next  = fill + 1'b1;
          state_next = last_q ? wmb_pkg::ST_RD_LO : wmb_pkg::ST_IDLE;
        end
      end

      wmb_pkg::ST_RD_LO: begin
        req.raddr  = lo_addr;
        state_next = wmb_pkg::ST_RD_HI;
      end

      wmb_pkg::ST_RD_HI: begin
        req.raddr = hi_addr;
        side_next = {rdata[wmb_pkg::DATA_W-1], rdata};
        if (!use_blend && fill[0]) begin
          median_next  = rdata;
          count_next   = 7'(fill);
          trunc_next   = dropped;
          done_next    = 1'b1;
          fill_next    = '0;
          dropped_next = 1'b0;
          state_next   = wmb_pkg::ST_IDLE;
        end else begin
          state_next = wmb_pkg::ST_RD_MID;
        end
      end

      wmb_pkg::ST_RD_MID: begin
        req.raddr = mid;
        side_next = pair_sum;
        if (!use_blend) begin
          // floor of the pair mean
          median_next  = pair_sum[wmb_pkg::DATA_W:1];
          count_next   = 7'(fill);
          trunc_next   = dropped;
          done_next    = 1'b1;
          fill_next    = '0;
          dropped_next = 1'b0;
          state_next   = wmb_pkg::ST_IDLE;
        end else begin
          state_next = wmb_pkg::ST_MUL_MID;
        end
      end

      wmb_pkg::ST_MUL_MID: begin
        mul_op.a   = {1'b0, f_eff, 1'b0};
        mul_op.b   = {rdata[wmb_pkg::DATA_W-1], rdata};
        state_next = wmb_pkg::ST_MUL_SIDE;
      end

      wmb_pkg::ST_MUL_SIDE: begin
        acc_next   = prod;
        mul_op.a   = {2'b00, f_rem};
        mul_op.b   = side;
        state_next = wmb_pkg::ST_SUM;
      end

      wmb_pkg::ST_SUM: begin
        // arithmetic shift of the exact sum
        median_next  = total[wmb_pkg::SHIFT_Q +: wmb_pkg::DATA_W];
        count_next   = 7'(fill);
        trunc_next   = dropped;
        done_next    = 1'b1;
        fill_next    = '0;
        dropped_next = 1'b0;
        state_next   = wmb_pkg::ST_IDLE;
      end

      default: begin
        state_next = wmb_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/window_median_with_blend_unit.sv
`timescale 1ns / 1ps
// Insertion walks the new sample past the k stored entries above it (k = 0..63).
// With last set, the result follows the low and high reads (plain, odd count), plus
// the middle read (plain, even) or it, both products and the sum (blend). busy stays
// high until the result strobe; a full window drops samples without an insertion walk.
// Synchronous reset empties the window and restores the register defaults.
// Results are flagged for a single cycle on done; the receiver cannot stall.
module window_median_with_blend_unit (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [wmb_pkg::PADDR_W-1:0]        paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready,
  input  logic                               start,
  output logic                               busy,
  input  logic signed [wmb_pkg::DATA_W-1:0]  sample,
  input  logic                               last,
  output logic                               done,
  output logic signed [wmb_pkg::DATA_W-1:0]  median,
  output logic [6:0]                         sample_count,
  output logic                               truncated
);

  logic                               blend_mode;
  logic [wmb_pkg::FACT_W-1:0]         blend_factor;
  logic                               reg_idx;
  wmb_pkg::mem_req_t                  req;
  logic [wmb_pkg::DATA_W-1:0]         rdata;
  wmb_pkg::mul_op_t                   mul_op;
  logic signed [wmb_pkg::PROD_W-1:0]  prod;

  assign pready  = 1'b1;
  assign reg_idx = paddr[2];

  // Register writes on the access phase of a transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      blend_mode   <= 1'b0;
      blend_factor <= wmb_pkg::FACTOR_RESET;
    end else if (psel && penable && pwrite && pready) begin
      case (reg_idx)
        wmb_pkg::REG_MODE:   blend_mode   <= pwdata[0];
        wmb_pkg::REG_FACTOR: blend_factor <= pwdata[wmb_pkg::FACT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Register readback
  always_comb begin
    case (reg_idx)
      wmb_pkg::REG_MODE:   prdata = {31'd0, blend_mode};
      wmb_pkg::REG_FACTOR: prdata = {{(32-wmb_pkg::FACT_W){1'b0}}, blend_factor};
      default:             prdata = '0;
    endcase
  end

  wmb_store u_store (
    .clk   (clk),
    .req   (req),
    .rdata (rdata)
  );

  wmb_mul u_mul (
    .clk  (clk),
    .op   (mul_op),
    .prod (prod)
  );

  wmb_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .sample       (sample),
    .last         (last),
    .blend_mode   (blend_mode),
    .blend_factor (blend_factor),
    .req          (req),
    .rdata        (rdata),
    .mul_op       (mul_op),
    .prod         (prod),
    .busy         (busy),
    .done         (done),
    .median       (median),
    .sample_count (sample_count),
    .truncated    (truncated)
  );

  // A window-closing transfer always occupies the unit
  a_last_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && last) |=> busy)
    else $error("last sample accepted without engaging the sequencer");

  // Result strobe comes as the unit returns to idle
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while still busy");

  // Strobe is a single-cycle pulse
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held over two cycles");

  // Every result reports at least one stored sample
  a_count_nz: assert property (@(posedge clk) disable iff (rst)
    done |-> (sample_count != 7'd0 || wmb_pkg::WINDOW > 127))
    else $error("result with empty window");

endmodule

>>> verif/testbench.sv
`timescale 1ns / 1ps
module testbench;

  localparam int LIMIT_CYCLES  = 1_000_000;
  localparam int SETTLE_CYCLES = 80;   // worst insertion walk plus blend pipeline
  localparam int PHASE_ITEMS   = 255;
  localparam logic [wmb_pkg::PADDR_W-1:0] MODE_ADDR   = {wmb_pkg::REG_MODE, 2'b00};
  localparam logic [wmb_pkg::PADDR_W-1:0] FACTOR_ADDR = {wmb_pkg::REG_FACTOR, 2'b00};
  localparam logic signed [wmb_pkg::DATA_W-1:0] S_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [wmb_pkg::DATA_W-1:0] S_MIN = 32'sh8000_0000;
  localparam longint Q16_ONE = wmb_pkg::FACTOR_ONE;

  typedef struct packed {
    logic signed [wmb_pkg::DATA_W-1:0] sample;
    logic                              last;
  } sample_xfer_t;

  typedef struct packed {
    logic signed [wmb_pkg::DATA_W-1:0] median;
    logic [6:0]                        count;
    logic                              truncated;
  } median_rec_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [wmb_pkg::PADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic start = 1'b0;
  logic busy;
  logic signed [wmb_pkg::DATA_W-1:0] sample = '0;
  logic last = 1'b0;
  logic done;
  logic signed [wmb_pkg::DATA_W-1:0] median;
  logic [6:0] sample_count;
  logic truncated;

  sample_xfer_t window_feed[$];
  median_rec_t  medians_due[$];
  int idle_pct = 8;
  int fail_count = 0;
  int cycle_count = 0;
  int samples_taken = 0, samples_dropped = 0, windows_closed = 0, settings_used = 1;

  // predictor copy of the window and the registers
  logic signed [wmb_pkg::DATA_W-1:0] sorted_vals [wmb_pkg::WINDOW];
  int held = 0;
  bit overflow = 1'b0;
  bit blend_on = 1'b0;
  logic [wmb_pkg::FACT_W-1:0] blend_wt = wmb_pkg::FACTOR_RESET;

  window_median_with_blend_unit dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .start(start), .busy(busy), .sample(sample), .last(last),
    .done(done), .median(median), .sample_count(sample_count),
    .truncated(truncated)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // insert one sample; on last, close the window and return its median
  function automatic bit window_push(input sample_xfer_t x, output median_rec_t r);
    int j;
    int m;
    longint wt;
    longint acc;
    if (held < wmb_pkg::WINDOW) begin
      j = held;
      while (j > 0 && sorted_vals[j-1] > x.sample) begin
        sorted_vals[j] = sorted_vals[j-1];
        j--;
      end
      sorted_vals[j] = x.sample;
      held++;
      samples_taken++;
    end else begin
      overflow = 1'b1;
      samples_dropped++;
    end
    if (!x.last) return 1'b0;
    m = held / 2;
    if (blend_on && held >= 3) begin
      // factor above one saturates to one
      wt = (blend_wt > wmb_pkg::FACTOR_ONE) ? Q16_ONE : longint'(blend_wt);
      acc = 2 * wt * longint'(sorted_vals[m])
          + (Q16_ONE - wt) * (longint'(sorted_vals[m-1]) + longint'(sorted_vals[m+1]));
      acc = acc >>> 17;
    end else if (held % 2 == 1) begin
      acc = longint'(sorted_vals[m]);
    end else begin
      acc = (longint'(sorted_vals[m-1]) + longint'(sorted_vals[m])) >>> 1;
    end
    r.median = wmb_pkg::DATA_W'(acc);
    r.count = 7'(held);
    r.truncated = overflow;
    held = 0;
    overflow = 1'b0;
    windows_closed++;
    return 1'b1;
  endfunction

  // driver: present queued samples, hold while busy
  always @(posedge clk) begin
    sample_xfer_t nxt;
    if (rst) begin
      start <= 1'b0;
    end else if (!start || !busy) begin
      if (window_feed.size() != 0 && $urandom_range(99) >= idle_pct) begin
        nxt = window_feed.pop_front();
        start <= 1'b1;
        sample <= nxt.sample;
        last <= nxt.last;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor: check results, then predict from the accepted transfer
  always @(posedge clk) begin
    median_rec_t due;
    median_rec_t res;
    sample_xfer_t got;
    if (!rst) begin
      if (done) begin
        if (medians_due.size() == 0) begin
          $error("result with no window closed: median %0d", $signed(median));
          fail_count++;
        end else begin
          due = medians_due.pop_front();
          if (median !== due.median) begin
            $error("median: expected %0d, got %0d", $signed(due.median), $signed(median));
            fail_count++;
          end
          if (sample_count !== due.count) begin
            $error("sample_count: expected %0d, got %0d", due.count, sample_count);
            fail_count++;
          end
          if (truncated !== due.truncated) begin
            $error("truncated: expected %0d, got %0d", due.truncated, truncated);
            fail_count++;
          end
        end
      end
      if (start && !busy) begin
        got.sample = sample;
        got.last = last;
        if (window_push(got, res)) medians_due.push_back(res);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic put(input logic signed [wmb_pkg::DATA_W-1:0] v, input logic l);
    window_feed.push_back('{v, l});
  endtask

  // wait until every sample is in and every median is out, then let the block settle
  task automatic settle();
    do @(negedge clk); while (window_feed.size() != 0 || start || medians_due.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic reg_write(input logic [wmb_pkg::PADDR_W-1:0] addr, input logic [31:0] data);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == MODE_ADDR) blend_on = data[0];
    else blend_wt = data[wmb_pkg::FACT_W-1:0];
    @(negedge clk);
  endtask

  function automatic logic signed [wmb_pkg::DATA_W-1:0] draw_sample();
    case ($urandom_range(9))
      0: begin
        case ($urandom_range(3))
          0: return S_MAX;
          1: return S_MIN;
          2: return '0;
          default: return -1;
        endcase
      end
      1, 2, 3: return int'($urandom_range(40)) - 20;   // near values, many ties
      default: return $urandom;
    endcase
  endfunction

  // mostly short windows, a few that fill or overflow
  function automatic int draw_length();
    int r;
    r = $urandom_range(99);
    if (r < 40) return $urandom_range(1, 3);
    if (r < 85) return $urandom_range(4, 12);
    if (r < 95) return $urandom_range(13, wmb_pkg::WINDOW - 1);
    return $urandom_range(wmb_pkg::WINDOW, wmb_pkg::WINDOW + 6);
  endfunction

  task automatic queue_window(input int len);
    for (int i = 0; i < len; i++) put(draw_sample(), i == len - 1);
  endtask

  initial begin
    int phase_items;
    int len;
    bit modes [6];
    int unsigned wts [6];
    modes = '{1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1};
    wts = '{0, wmb_pkg::FACTOR_ONE, 131071, $urandom_range(131071), $urandom_range(65536),
            65537};

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // plain median at reset settings: extremes, rounding down, ties
    put(S_MAX, 1'b1);
    put(S_MIN, 1'b1);
    put(S_MAX, 1'b0); put(S_MIN, 1'b1);
    put(-3, 1'b0); put(-4, 1'b1);
    put(5, 1'b0); put(5, 1'b0); put(5, 1'b1);
    put(7, 1'b0); put(-1, 1'b0); put(3, 1'b0); put(0, 1'b1);
    settle();

    // blend at the default factor, including the fewer-than-three fallback
    reg_write(MODE_ADDR, 32'd1);
    settings_used++;
    put(9, 1'b1);
    put(S_MIN, 1'b0); put(S_MAX, 1'b1);
    put(10, 1'b0); put(30, 1'b0); put(20, 1'b1);
    put(S_MIN, 1'b0); put(S_MAX, 1'b0); put(S_MIN, 1'b0); put(S_MAX, 1'b1);

    // random windows under several register settings and idle profiles
    for (int p = 0; p < 6; p++) begin
      settle();
      reg_write(MODE_ADDR, 32'(modes[p]));
      reg_write(FACTOR_ADDR, wts[p]);
      settings_used++;
      idle_pct = (p < 2) ? 8 : (p < 4) ? 85 : 0;
      phase_items = 0;
      if (p == 0) begin
        // overflow up front: last arrives on a dropped sample
        queue_window(wmb_pkg::WINDOW + 2);
        phase_items = wmb_pkg::WINDOW + 2;
      end
      while (phase_items < PHASE_ITEMS) begin
        len = draw_length();
        queue_window(len);
        phase_items += len;
        if ($urandom_range(24) == 0) settle();
      end
    end
    settle();

    $display("covered %0d samples stored, %0d dropped at a full window, %0d windows closed",
             samples_taken, samples_dropped, windows_closed);
    $display("across %0d register settings and three idle profiles", settings_used);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/wmb_pkg.sv
rtl/wmb_store.sv
rtl/wmb_mul.sv
rtl/wmb_ctrl.sv
rtl/window_median_with_blend_unit.sv
verif/testbench.sv
